@@ rtl/core/uff_pkg.sv @@
// Shared types and constants of the union-find spanning forest block
`timescale 1ns / 1ps
`default_nettype none

package uff_pkg;

    // table size and field widths
    localparam int MAX_VERTICES = 1024;
    localparam int VTX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = 11;
    localparam int EDGE_W       = 16;
    localparam int STATUS_W     = 2;

    localparam logic [CNT_W-1:0] VERTEX_COUNT_RESET = CNT_W'(1024);

    // stream packing: input tdata and output tdata widths in whole bytes
    localparam int IN_BITS   = EDGE_W + 2 * VTX_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = EDGE_W + STATUS_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_JOINED  = 2'd0,
        STAT_SKIPPED = 2'd1,
        STAT_RANGE   = 2'd2
    } uff_status_t;

    // request classes decided at the front
    typedef enum logic [1:0] {
        CLS_EDGE    = 2'd0,
        CLS_RANGE   = 2'd1,
        CLS_RESTART = 2'd2
    } uff_class_t;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR = 3'd0,
        ST_IDLE  = 3'd1,
        ST_FIND  = 3'd2,
        ST_COMP  = 3'd3,
        ST_DONE  = 3'd4
    } uff_state_t;

    // classified request as it sits in the queue
    typedef struct packed {
        uff_class_t             cls;
        logic [EDGE_W-1:0]      edge_index;
        logic [VTX_W-1:0]       vertex_a;
        logic [VTX_W-1:0]       vertex_b;
    } uff_req_t;

    // back-end status seen by the top level
    typedef struct packed {
        logic clearing;
        logic idle;
    } uff_back_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/uff_front.sv @@
// Front end: vertex count register, request unpacking and classification
`timescale 1ns / 1ps
`default_nettype none

module uff_front
    import uff_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CNT_W-1:0]      cfg_data,
    // incoming requests
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  wire logic [0:0]            s_axis_tuser,
    // push side of the queue
    output logic                       push_valid,
    input  wire logic                  push_ready,
    output uff_req_t                   push_req
);

    logic [CNT_W-1:0] vertex_count_reg;
    logic [CNT_W-1:0] vertex_count_next;
    logic [CNT_W-1:0] limit;
    logic [VTX_W-1:0] va;
    logic [VTX_W-1:0] vb;
    logic             in_range;

    // vertex count register, writable at any time
    assign cfg_ready = 1'b1;

    always_comb
    begin
        vertex_count_next = vertex_count_reg;
        if (cfg_valid)
        begin
            vertex_count_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VERTEX_COUNT_RESET;
        end
        else
        begin
            vertex_count_reg <= vertex_count_next;
        end
    end

    // unpack the edge and check both ends against the clamped count
    assign va = s_axis_tdata[EDGE_W +: VTX_W];
    assign vb = s_axis_tdata[EDGE_W + VTX_W +: VTX_W];

    assign limit = (vertex_count_reg > CNT_W'(MAX_VERTICES)) ?
                   CNT_W'(MAX_VERTICES) : vertex_count_reg;

    assign in_range = (CNT_W'(va) < limit) && (CNT_W'(vb) < limit);

    // classify and hand over to the queue
    always_comb
    begin
        push_req.edge_index = s_axis_tdata[EDGE_W-1:0];
        push_req.vertex_a   = va;
        push_req.vertex_b   = vb;
        if (s_axis_tuser[0])
        begin
            push_req.cls = CLS_RESTART;
        end
        else if (!in_range)
        begin
            push_req.cls = CLS_RANGE;
        end
        else
        begin
            push_req.cls = CLS_EDGE;
        end
    end

    assign push_valid    = s_axis_tvalid;
    assign s_axis_tready = push_ready;

endmodule

`default_nettype wire

@@ rtl/core/uff_queue.sv @@
// Two-entry request queue between the front end and the back end
`timescale 1ns / 1ps
`default_nettype none

module uff_queue
    import uff_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push_valid,
    output logic          push_ready,
    input  wire uff_req_t push_req,
    output logic          pop_valid,
    input  wire logic     pop,
    output uff_req_t      pop_req
);

    uff_req_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_req    = entry_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop && pop_valid;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/uff_back.sv @@
// Back end: parent table memory, find and compress sequencer, result register
`timescale 1ns / 1ps
`default_nettype none

module uff_back
    import uff_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // pop side of the queue
    input  wire logic                   q_valid,
    output logic                        q_pop,
    input  wire uff_req_t               q_req,
    // results
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // status
    output uff_back_stat_t              stat
);

    logic [VTX_W-1:0] parent_mem [MAX_VERTICES];
    logic [VTX_W-1:0] rd_data_reg;

    uff_state_t        state_reg, state_next;
    logic [VTX_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [VTX_W-1:0]  cur_reg, cur_next;
    logic [VTX_W-1:0]  orig_reg, orig_next;
    logic [VTX_W-1:0]  vb_reg, vb_next;
    logic [VTX_W-1:0]  root_reg, root_next;
    logic [VTX_W-1:0]  ra_reg, ra_next;
    logic              phase_b_reg, phase_b_next;
    logic [EDGE_W-1:0] edge_reg, edge_next;
    uff_status_t       status_reg, status_next;
    logic              out_valid_reg, out_valid_next;
    logic [EDGE_W-1:0] out_edge_reg, out_edge_next;
    uff_status_t       out_status_reg, out_status_next;

    logic              mem_we;
    logic [VTX_W-1:0]  mem_wa;
    logic [VTX_W-1:0]  mem_wd;
    logic              mem_re;
    logic [VTX_W-1:0]  mem_ra;

    // parent table, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            parent_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= parent_mem[mem_ra];
        end
    end

    // sequencer state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            phase_b_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            phase_b_reg   <= phase_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        orig_reg       <= orig_next;
        vb_reg         <= vb_next;
        root_reg       <= root_next;
        ra_reg         <= ra_next;
        edge_reg       <= edge_next;
        status_reg     <= status_next;
        out_edge_reg   <= out_edge_next;
        out_status_reg <= out_status_next;
    end

    // next state: clearing sweep, root walk, path compression, link, result
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        cur_next        = cur_reg;
        orig_next       = orig_reg;
        vb_next         = vb_reg;
        root_next       = root_reg;
        ra_next         = ra_reg;
        phase_b_next    = phase_b_reg;
        edge_next       = edge_reg;
        status_next     = status_reg;
        out_edge_next   = out_edge_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        mem_wa          = cur_reg;
        mem_wd          = root_reg;
        mem_re          = 1'b0;
        mem_ra          = cur_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_cnt_reg;
                mem_wd = clr_cnt_reg;
                if (clr_cnt_reg == VTX_W'(MAX_VERTICES - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + VTX_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    edge_next = q_req.edge_index;
                    case (q_req.cls)
                        CLS_RESTART:
                        begin
                            clr_cnt_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        CLS_RANGE:
                        begin
                            status_next = STAT_RANGE;
                            state_next  = ST_DONE;
                        end
                        default:
                        begin
                            mem_re       = 1'b1;
                            mem_ra       = q_req.vertex_a;
                            cur_next     = q_req.vertex_a;
                            orig_next    = q_req.vertex_a;
                            vb_next      = q_req.vertex_b;
                            phase_b_next = 1'b0;
                            state_next   = ST_FIND;
                        end
                    endcase
                end
            end

            ST_FIND:
            begin
                // rd_data_reg holds the parent of cur_reg
                mem_re = 1'b1;
                if (rd_data_reg == cur_reg)
                begin
                    root_next  = cur_reg;
                    mem_ra     = orig_reg;
                    cur_next   = orig_reg;
                    state_next = ST_COMP;
                end
                else
                begin
                    mem_ra   = rd_data_reg;
                    cur_next = rd_data_reg;
                end
            end

            ST_COMP:
            begin
                if (rd_data_reg == cur_reg)
                begin
                    if (!phase_b_reg)
                    begin
                        // first end done, walk the second end
                        ra_next      = root_reg;
                        mem_re       = 1'b1;
                        mem_ra       = vb_reg;
                        cur_next     = vb_reg;
                        orig_next    = vb_reg;
                        phase_b_next = 1'b1;
                        state_next   = ST_FIND;
                    end
                    else
                    begin
                        // both roots known: link or skip
                        if (root_reg == ra_reg)
                        begin
                            status_next = STAT_SKIPPED;
                        end
                        else
                        begin
                            mem_we      = 1'b1;
                            mem_wa      = root_reg;
                            mem_wd      = ra_reg;
                            status_next = STAT_JOINED;
                        end
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    // point this path entry at the root and move up
                    mem_we   = 1'b1;
                    mem_wa   = cur_reg;
                    mem_wd   = root_reg;
                    mem_re   = 1'b1;
                    mem_ra   = rd_data_reg;
                    cur_next = rd_data_reg;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_edge_next   = edge_reg;
                    out_status_next = status_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result channel and status
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_status_reg, out_edge_reg});

    assign stat.clearing = (state_reg == ST_CLEAR);
    assign stat.idle     = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

@@ rtl/core/union_find_spanning_forest.sv @@
// Top level of the union-find spanning forest builder
//
// Requests arrive on the s_axis channel: tuser high restarts the forest (the
// parent table returns to the identity, no result), tuser low carries one
// edge. Each edge gives one result on m_axis with its id and a status:
// joined, skipped (both ends already in one tree) or out of range (an end at
// or beyond vertex_count, table untouched). vertex_count is written on the
// cfg channel; reset value 1024, clamped to the table size.
// A front end classifies requests into a two-entry queue; the back end walks
// the parent table in a memory with one read and one write port, one parent
// read per cycle. For an edge it walks from each end to its root, pointing
// every entry on the path at the root, then links the two roots or skips the
// edge. An out-of-range edge only returns its status. A restart, and reset
// itself, runs a clearing pass over all 1024 table entries; during it no queued
// request is started, and s_axis_tready drops once the queue holds two requests.
// The result sits in an output register: while m_axis_tready is low the
// back end holds the next result and the queue keeps taking requests until full.
`timescale 1ns / 1ps
`default_nettype none

module union_find_spanning_forest
    import uff_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration: vertex_count
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CNT_W-1:0]       cfg_data,
    // requests
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // edge_index, vertex_a, vertex_b
    input  wire logic [0:0]             s_axis_tuser,   // kind
    // results
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata    // edge_id, status
);

    logic           push_valid;
    logic           push_ready;
    uff_req_t       push_req;
    logic           q_valid;
    logic           q_pop;
    uff_req_t       q_req;
    uff_back_stat_t back_stat;

    // request classification
    uff_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_req      (push_req)
    );

    // decoupling queue
    uff_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_req    (q_req)
    );

    // table walker
    uff_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_req         (q_req),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .stat          (back_stat)
    );

    // a request leaves the queue only when present and the walker is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_valid && back_stat.idle))
    else $error("queue popped while empty or walker busy");

    // a restart request starts the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_req.cls == CLS_RESTART) |=> back_stat.clearing)
    else $error("restart did not start clearing pass");

    // results carry only defined status codes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[EDGE_W +: STATUS_W] == STAT_JOINED ||
                           m_axis_tdata[EDGE_W +: STATUS_W] == STAT_SKIPPED ||
                           m_axis_tdata[EDGE_W +: STATUS_W] == STAT_RANGE))
    else $error("undefined status code on result");

endmodule

`default_nettype wire
